@@ sv/set_assoc_cache_tag_lookup_defines.svh @@
// Assertion macros shared by the tag lookup modules.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset.
`define SATL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check on every clock edge, reset included.
`define SATL_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SATL_ASSERT(name, prop, msg)
`define SATL_ASSERT_RST(name, prop, msg)
`endif

`endif

@@ sv/satl_pkg.sv @@
package satl_pkg;

  localparam int TAG_W           = 32;
  localparam int OFFSET_W        = 6;
  localparam int OFFSET_LOG2_MAX = 6;
  localparam int SET_OUT_W       = 6;
  localparam int WAY_OUT_W       = 3;
  localparam int VICTIM_W        = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 3;

  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_FILL    = 2'd1,
    OUT_REPLACE = 2'd2
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_SIZE_LOG2 = 2'd0,
    CFG_SETS_LOG2      = 2'd1,
    CFG_WAYS_LOG2      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0] line_size_log2;
    logic [2:0] sets_log2;
    logic [1:0] ways_log2;
  } cfg_t;

endpackage

@@ sv/satl_store.sv @@
`include "set_assoc_cache_tag_lookup_defines.svh"

module satl_store #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8,
  parameter int SET_IDX_W = 6,
  parameter int WAY_IDX_W = 3
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      rd_en_i,
  input  logic [SET_IDX_W-1:0]                      rd_set_i,
  input  logic                                      wr_en_i,
  input  logic [SET_IDX_W-1:0]                      wr_set_i,
  input  logic [WAY_IDX_W-1:0]                      wr_way_i,
  input  logic [satl_pkg::TAG_W-1:0]                wr_tag_i,
  input  logic [MAX_WAYS-1:0]                       wr_vrow_i,
  output logic [MAX_WAYS-1:0][satl_pkg::TAG_W-1:0]  rd_tags_o,
  output logic [MAX_WAYS-1:0]                       rd_vrow_o,
  output logic                                      busy_o
);
  import satl_pkg::*;

  localparam logic [SET_IDX_W-1:0] LastRow = SET_IDX_W'(MAX_SETS - 1);

  logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [MAX_SETS];
  logic [MAX_WAYS-1:0]            vld_mem [MAX_SETS];

  logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tags_q;
  logic [MAX_WAYS-1:0]            rd_vrow_q;

  logic                 clr_q, clr_d;
  logic [SET_IDX_W-1:0] clr_cnt_q, clr_cnt_d;

  // Sweep every row once after reset to empty all ways.
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + SET_IDX_W'(1);
      if (clr_cnt_q == LastRow) begin
        clr_d     = 1'b0;
        clr_cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_mem[wr_set_i][wr_way_i] <= wr_tag_i;
    end
    if (rd_en_i) begin
      rd_tags_q <= tag_mem[rd_set_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      vld_mem[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      vld_mem[wr_set_i] <= wr_vrow_i;
    end
    if (rd_en_i) begin
      rd_vrow_q <= vld_mem[rd_set_i];
    end
  end

  assign rd_tags_o = rd_tags_q;
  assign rd_vrow_o = rd_vrow_q;
  assign busy_o    = clr_q;

  `SATL_ASSERT(a_no_write_in_clear, clr_q |-> !wr_en_i, "request write during clearing pass")
  `SATL_ASSERT(a_clear_complete, $fell(clr_q) |-> $past(clr_cnt_q) == LastRow, "clearing pass cut short")
  `SATL_ASSERT_RST(a_busy_in_reset, !rst_ni |-> busy_o, "busy low while in reset")

endmodule

@@ sv/set_assoc_cache_tag_lookup.sv @@
// Set-associative tag lookup: one address request per cycle, accepted while start is high
// and busy is low. Each request passes through the lookup stage registers, with the registered
// read of the set's tag row, and then the result register, giving its result on done_o for
// exactly one cycle; the receiver cannot stall, so results must be taken as they appear.
// Back-to-back requests to the same set are forwarded, so no gap is needed.
// After reset, busy stays high while every set is marked empty.
// Configuration writes take effect at once and must be made while no request is in flight.
`include "set_assoc_cache_tag_lookup_defines.svh"

module set_assoc_cache_tag_lookup #(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [ADDR_WIDTH-1:0]               address_i,
  input  logic [satl_pkg::VICTIM_W-1:0]       victim_way_i,
  input  logic                                cfg_we_i,
  input  logic [satl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [satl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic                                done_o,
  output logic [1:0]                          outcome_o,
  output logic [satl_pkg::WAY_OUT_W-1:0]      way_index_o,
  output logic [satl_pkg::SET_OUT_W-1:0]      set_index_o,
  output logic [satl_pkg::TAG_W-1:0]          tag_value_o,
  output logic [satl_pkg::OFFSET_W-1:0]       offset_value_o
);
  import satl_pkg::*;

  localparam int SetIdxW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WayIdxW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SetLog2Max = $clog2(MAX_SETS + 1) - 1;
  localparam int WayLog2Max = $clog2(MAX_WAYS + 1) - 1;
  localparam int ExtW       = (ADDR_WIDTH > TAG_W) ? ADDR_WIDTH : TAG_W;
  localparam int SetMaskW   = SetIdxW + 1;
  localparam int WayMaskW   = MAX_WAYS + 1;

  // Configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_size_log2 <= 3'd4;
      cfg_q.sets_log2      <= 3'd6;
      cfg_q.ways_log2      <= 2'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINE_SIZE_LOG2: cfg_q.line_size_log2 <= cfg_wdata_i;
        CFG_SETS_LOG2:      cfg_q.sets_log2      <= cfg_wdata_i;
        CFG_WAYS_LOG2:      cfg_q.ways_log2      <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Address split
  logic                 accept;
  logic                 store_busy;
  logic [2:0]           lb, sb;
  logic [1:0]           wb;
  logic [3:0]           shamt;
  logic [ExtW-1:0]      addr_ext, set_sh;
  logic [OFFSET_W-1:0]  s0_off;
  logic [SetIdxW-1:0]   s0_set;
  logic [TAG_W-1:0]     s0_tag;
  logic [MAX_WAYS-1:0]  s0_en;
  logic [WayIdxW-1:0]   s0_victim;

  assign accept = start && !store_busy;
  assign busy   = store_busy;

  always_comb begin
    lb = (int'(cfg_q.line_size_log2) > OFFSET_LOG2_MAX) ? 3'(OFFSET_LOG2_MAX)
                                                          : cfg_q.line_size_log2;
    sb = (int'(cfg_q.sets_log2) > SetLog2Max) ? 3'(SetLog2Max) : cfg_q.sets_log2;
    wb = (int'(cfg_q.ways_log2) > WayLog2Max) ? 2'(WayLog2Max) : cfg_q.ways_log2;
    shamt     = 4'(lb) + 4'(sb);
    addr_ext  = ExtW'(address_i);
    s0_off    = OFFSET_W'(addr_ext) & OFFSET_W'((7'd1 << lb) - 7'd1);
    set_sh    = addr_ext >> lb;
    s0_set    = SetIdxW'(set_sh) & SetIdxW'((SetMaskW'(1) << sb) - SetMaskW'(1));
    s0_tag    = TAG_W'(addr_ext >> shamt);
    // one enable bit per way in use, 2**wb of them
    s0_en     = MAX_WAYS'((WayMaskW'(1) << (4'd1 << wb)) - WayMaskW'(1));
    s0_victim = WayIdxW'(victim_way_i) & WayIdxW'((4'd1 << wb) - 4'd1);
  end

  // Lookup stage registers
  logic                 s1_vld_q;
  logic [SetIdxW-1:0]   s1_set_q;
  logic [TAG_W-1:0]     s1_tag_q;
  logic [OFFSET_W-1:0]  s1_off_q;
  logic [MAX_WAYS-1:0]  s1_en_q;
  logic [WayIdxW-1:0]   s1_victim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_set_q    <= s0_set;
      s1_tag_q    <= s0_tag;
      s1_off_q    <= s0_off;
      s1_en_q     <= s0_en;
      s1_victim_q <= s0_victim;
    end
  end

  // Tag and valid storage
  logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tags;
  logic [MAX_WAYS-1:0]            rd_vrow;
  logic                           wr_en;
  logic [WayIdxW-1:0]             wr_way;
  logic [MAX_WAYS-1:0]            wr_vrow;

  satl_store #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .SET_IDX_W (SetIdxW),
    .WAY_IDX_W (WayIdxW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_set_i  (s0_set),
    .wr_en_i   (wr_en),
    .wr_set_i  (s1_set_q),
    .wr_way_i  (wr_way),
    .wr_tag_i  (s1_tag_q),
    .wr_vrow_i (wr_vrow),
    .rd_tags_o (rd_tags),
    .rd_vrow_o (rd_vrow),
    .busy_o    (store_busy)
  );

  // Forward the previous request's write when it went to the same set
  logic               byp_vld_q;
  logic [SetIdxW-1:0] byp_set_q;
  logic [WayIdxW-1:0] byp_way_q;
  logic [TAG_W-1:0]   byp_tag_q;
  logic               byp_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_vld_q <= 1'b0;
    end else begin
      byp_vld_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      byp_set_q <= s1_set_q;
      byp_way_q <= wr_way;
      byp_tag_q <= s1_tag_q;
    end
  end

  assign byp_hit = byp_vld_q && (byp_set_q == s1_set_q);

  // Compare and choose the way
  logic [MAX_WAYS-1:0] vrow;
  logic [MAX_WAYS-1:0] hit_vec, empty_vec;
  logic [WayIdxW-1:0]  hit_way, empty_way;
  logic                any_hit, any_empty;
  outcome_e            s1_outcome;
  logic [WayIdxW-1:0]  s1_way;

  always_comb begin
    logic [TAG_W-1:0] way_tag;
    logic             patch;
    for (int w = 0; w < MAX_WAYS; w++) begin
      patch        = byp_hit && (byp_way_q == WayIdxW'(w));
      way_tag      = patch ? byp_tag_q : rd_tags[w];
      vrow[w]      = rd_vrow[w] | patch;
      hit_vec[w]   = s1_en_q[w] & vrow[w] & (way_tag == s1_tag_q);
      empty_vec[w] = s1_en_q[w] & ~vrow[w];
    end
  end

  always_comb begin
    hit_way   = '0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WayIdxW'(w);
      end
      if (empty_vec[w]) begin
        empty_way = WayIdxW'(w);
      end
    end
    any_hit   = |hit_vec;
    any_empty = |empty_vec;
    if (any_hit) begin
      s1_outcome = OUT_HIT;
      s1_way     = hit_way;
    end else if (any_empty) begin
      s1_outcome = OUT_FILL;
      s1_way     = empty_way;
    end else begin
      s1_outcome = OUT_REPLACE;
      s1_way     = s1_victim_q;
    end
    wr_en   = s1_vld_q && !any_hit;
    wr_way  = s1_way;
    wr_vrow = vrow | MAX_WAYS'(WayMaskW'(1) << s1_way);
  end

  // Result register
  logic                 done_q;
  outcome_e             outcome_q;
  logic [WayIdxW-1:0]   way_q;
  logic [SetIdxW-1:0]   set_q;
  logic [TAG_W-1:0]     tag_q;
  logic [OFFSET_W-1:0]  off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      outcome_q <= s1_outcome;
      way_q     <= s1_way;
      set_q     <= s1_set_q;
      tag_q     <= s1_tag_q;
      off_q     <= s1_off_q;
    end
  end

  assign done_o         = done_q;
  assign outcome_o      = 2'(outcome_q);
  assign way_index_o    = WAY_OUT_W'(way_q);
  assign set_index_o    = SET_OUT_W'(set_q);
  assign tag_value_o    = tag_q;
  assign offset_value_o = off_q;

  `SATL_ASSERT(a_result_latency, start && !busy |-> ##2 done_o, "request result missing")
  `SATL_ASSERT(a_hit_no_write, s1_vld_q && any_hit |-> !wr_en, "write on tag hit")
  `SATL_ASSERT(a_fwd_source, s1_vld_q && byp_hit |=> 1'b1 ##0 $past(byp_vld_q), "forward without write")

endmodule

@@ bench/set_assoc_cache_tag_lookup_tb.sv @@
`timescale 1ns / 100ps

module set_assoc_cache_tag_lookup_tb;
  import satl_pkg::*;

  localparam int MAX_SETS      = 64;
  localparam int MAX_WAYS      = 8;
  localparam int ADDR_WIDTH    = 32;
  localparam int SETS_LOG2_MAX = $clog2(MAX_SETS);
  localparam int WAYS_LOG2_MAX = $clog2(MAX_WAYS);
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;
  localparam int PHASE_ITEMS   = 120;
  localparam int NUM_PHASES    = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    REQ_LOOKUP,
    REQ_CFG,
    REQ_QUIESCE
  } req_kind_e;

  typedef struct {
    req_kind_e             kind;
    logic [ADDR_WIDTH-1:0] addr;
    logic [VICTIM_W-1:0]   victim;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           gap;
  } pending_req_t;

  typedef struct packed {
    outcome_e              outcome;
    logic [WAY_OUT_W-1:0]  way_idx;
    logic [SET_OUT_W-1:0]  set_idx;
    logic [TAG_W-1:0]      tag_val;
    logic [OFFSET_W-1:0]   offset_val;
  } lookup_result_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b1;
  logic                  start        = 1'b0;
  logic                  busy;
  logic [ADDR_WIDTH-1:0] address_i    = '0;
  logic [VICTIM_W-1:0]   victim_way_i = '0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                  done_o;
  logic [1:0]            outcome_o;
  logic [WAY_OUT_W-1:0]  way_index_o;
  logic [SET_OUT_W-1:0]  set_index_o;
  logic [TAG_W-1:0]      tag_value_o;
  logic [OFFSET_W-1:0]   offset_value_o;

  // Predictor state: tag array, valid bits and the live configuration.
  logic [TAG_W-1:0] tag_mem [MAX_SETS*MAX_WAYS];
  bit               valid_mem [MAX_SETS*MAX_WAYS];
  logic [2:0]       line_cfg = 3'd4;
  logic [2:0]       sets_cfg = 3'd6;
  logic [1:0]       ways_cfg = 2'd3;

  // Configuration as seen by the stimulus generator.
  int unsigned plan_line = 4;
  int unsigned plan_sets = 6;
  int unsigned plan_ways = 3;

  pending_req_t   pending_reqs[$];
  lookup_result_t expected_lookups[$];
  int unsigned    gap_left;
  int unsigned    quiet_cycles;
  int unsigned    mismatch_cnt;
  int unsigned    result_cnt;
  int unsigned    cycle_cnt;

  set_assoc_cache_tag_lookup #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .address_i     (address_i),
    .victim_way_i  (victim_way_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .outcome_o     (outcome_o),
    .way_index_o   (way_index_o),
    .set_index_o   (set_index_o),
    .tag_value_o   (tag_value_o),
    .offset_value_o(offset_value_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Drop reset before the first edge so the asynchronous reset takes hold at once.
  initial begin
    #1 rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_LINE_SIZE_LOG2: line_cfg = data;
      CFG_SETS_LOG2:      sets_cfg = data;
      CFG_WAYS_LOG2:      ways_cfg = data[1:0];
      default: ;
    endcase
  endfunction

  function automatic lookup_result_t predict_lookup(logic [ADDR_WIDTH-1:0] addr,
                                                    logic [VICTIM_W-1:0] victim);
    int unsigned    lb, sb, nways, base, w;
    logic [31:0]    set_full, offset_full;
    bit             found;
    lookup_result_t res;
    lb          = (line_cfg > OFFSET_LOG2_MAX) ? OFFSET_LOG2_MAX : line_cfg;
    sb          = (sets_cfg > SETS_LOG2_MAX) ? SETS_LOG2_MAX : sets_cfg;
    nways       = 1 << ((ways_cfg > WAYS_LOG2_MAX) ? WAYS_LOG2_MAX : ways_cfg);
    offset_full = addr & ((32'd1 << lb) - 32'd1);
    set_full    = (addr >> lb) & ((32'd1 << sb) - 32'd1);
    res.offset_val = offset_full[OFFSET_W-1:0];
    res.set_idx    = set_full[SET_OUT_W-1:0];
    res.tag_val    = addr >> (lb + sb);
    base  = set_full * MAX_WAYS;
    found = 1'b0;
    res.outcome = OUT_REPLACE;
    res.way_idx = WAY_OUT_W'(victim & (nways - 1));
    for (w = 0; w < nways; w++) begin
      if (!found && valid_mem[base+w] && tag_mem[base+w] == res.tag_val) begin
        found       = 1'b1;
        res.outcome = OUT_HIT;
        res.way_idx = w[WAY_OUT_W-1:0];
      end
    end
    // no hit: take the lowest empty way before falling back to the victim
    for (w = 0; w < nways; w++) begin
      if (!found && !valid_mem[base+w]) begin
        found       = 1'b1;
        res.outcome = OUT_FILL;
        res.way_idx = w[WAY_OUT_W-1:0];
      end
    end
    if (res.outcome != OUT_HIT) begin
      tag_mem[base+res.way_idx]   = res.tag_val;
      valid_mem[base+res.way_idx] = 1'b1;
    end
    return res;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX) $display("%s", msg);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_lookup(logic [ADDR_WIDTH-1:0] addr, logic [VICTIM_W-1:0] victim,
                                     int unsigned gap);
    pending_req_t req;
    req = '{kind: REQ_LOOKUP, addr: addr, victim: victim, cfg_idx: '0, cfg_data: '0, gap: gap};
    pending_reqs.push_back(req);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    pending_req_t req;
    req = '{kind: REQ_CFG, addr: '0, victim: '0, cfg_idx: idx, cfg_data: data, gap: 0};
    pending_reqs.push_back(req);
    case (idx)
      CFG_LINE_SIZE_LOG2: plan_line = data;
      CFG_SETS_LOG2:      plan_sets = data;
      CFG_WAYS_LOG2:      plan_ways = data & 3;
      default: ;
    endcase
  endfunction

  function automatic void add_quiesce();
    pending_req_t req;
    req = '{kind: REQ_QUIESCE, addr: '0, victim: '0, cfg_idx: '0, cfg_data: '0, gap: 0};
    pending_reqs.push_back(req);
  endfunction

  // Mostly accesses from a small tag pool into a few sets, so hits, fills and
  // replacements all happen; the rest are random addresses.
  function automatic void add_random_phase(int unsigned n);
    int unsigned           lb, sb, nways, npool, calm, k, i;
    logic [31:0]           tag_pool [20];
    logic [31:0]           focus [4];
    logic [ADDR_WIDTH-1:0] addr;
    lb    = (plan_line > OFFSET_LOG2_MAX) ? OFFSET_LOG2_MAX : plan_line;
    sb    = (plan_sets > SETS_LOG2_MAX) ? SETS_LOG2_MAX : plan_sets;
    nways = 1 << plan_ways;
    npool = nways + $urandom_range(0, nways + 1);
    for (i = 0; i < npool; i++) tag_pool[i] = $urandom();
    for (i = 0; i < 4; i++) focus[i] = $urandom_range(0, (1 << sb) - 1);
    calm = 0;
    for (k = 0; k < n; k++) begin
      if (calm == 0 && $urandom_range(0, 29) == 0) calm = $urandom_range(5, 30);
      if ($urandom_range(0, 9) < 8)
        addr = (tag_pool[$urandom_range(0, npool - 1)] << (lb + sb))
             | (focus[$urandom_range(0, 3)] << lb)
             | ($urandom() & ((32'd1 << lb) - 32'd1));
      else
        addr = $urandom();
      add_lookup(addr, VICTIM_W'($urandom_range(0, 7)), (calm != 0) ? 0 : pick_gap());
      if (calm != 0) calm--;
      if (k == n / 2 && $urandom_range(0, 1) == 1) add_quiesce();
    end
  endfunction

  // Driver: issue pending requests, write registers only when nothing is in flight.
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_start;
    logic nxt_we;
    if (!rst_ni) begin
      start        <= 1'b0;
      cfg_we_i     <= 1'b0;
      gap_left     = 0;
      quiet_cycles = 0;
    end else begin
      nxt_start = start;
      nxt_we    = 1'b0;
      if (start && !busy) begin
        expected_lookups.push_back(predict_lookup(address_i, victim_way_i));
        nxt_start = 1'b0;
      end
      if (expected_lookups.size() == 0 && !start) quiet_cycles++;
      else quiet_cycles = 0;
      if (!nxt_start) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          case (pending_reqs[0].kind)
            REQ_LOOKUP: begin
              nxt_start = 1'b1;
              address_i    <= pending_reqs[0].addr;
              victim_way_i <= pending_reqs[0].victim;
              gap_left = pending_reqs[0].gap;
              void'(pending_reqs.pop_front());
            end
            default: begin
              if (quiet_cycles >= SETTLE_CYCLES && !busy) begin
                if (pending_reqs[0].kind == REQ_CFG) begin
                  nxt_we = 1'b1;
                  cfg_idx_i   <= pending_reqs[0].cfg_idx;
                  cfg_wdata_i <= pending_reqs[0].cfg_data;
                  apply_cfg(pending_reqs[0].cfg_idx, pending_reqs[0].cfg_data);
                end
                void'(pending_reqs.pop_front());
              end
            end
          endcase
        end
      end
      start    <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  // Monitor: every strobed result must match the oldest outstanding request.
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && done_o) begin
      result_cnt++;
      if (expected_lookups.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with no request outstanding", result_cnt));
      end else begin
        want = expected_lookups.pop_front();
        if (outcome_o !== want.outcome || way_index_o !== want.way_idx
            || set_index_o !== want.set_idx || tag_value_o !== want.tag_val
            || offset_value_o !== want.offset_val)
          note_mismatch($sformatf({"result %0d: exp outcome %0d way %0d set %0d tag %h off %0d",
                                   " / got outcome %0d way %0d set %0d tag %h off %0d"},
                                  result_cnt, want.outcome, want.way_idx, want.set_idx,
                                  want.tag_val, want.offset_val, outcome_o, way_index_o,
                                  set_index_o, tag_value_o, offset_value_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned cfg_plan [5][3];
    int unsigned p, i;
    cfg_plan = '{'{7, 7, 3}, '{0, 0, 0}, '{2, 3, 2}, '{0, 6, 1}, '{6, 0, 3}};

    // Reset configuration: 16-byte lines, 64 sets, 8 ways.
    add_lookup(32'h0000_0000, 3'd0, 0);
    add_lookup(32'h0000_0000, 3'd7, 0);
    add_lookup(32'hFFFF_FFFF, 3'd7, 1);
    add_lookup(32'hFFFF_FFF0, 3'd0, 0);
    // fill every way of set 5, then overflow it
    for (i = 1; i <= 8; i++) add_lookup((i << 10) | (5 << 4), 3'd0, (i == 4) ? 2 : 0);
    add_lookup((32'd9 << 10) | (5 << 4) | 32'hF, 3'd7, 0);
    add_lookup((32'd9 << 10) | (5 << 4), 3'd2, 1);
    add_lookup((32'd10 << 10) | (5 << 4), 3'd0, 0);
    add_lookup((32'd1 << 10) | (5 << 4), 3'd3, 0);
    add_quiesce();

    // One set of one way, no offset: the whole address is the tag, victim masked off.
    add_cfg(CFG_LINE_SIZE_LOG2, 3'd0);
    add_cfg(CFG_SETS_LOG2, 3'd0);
    add_cfg(CFG_WAYS_LOG2, 3'd0);
    add_cfg(CFG_IDX_UNUSED, 3'd7);
    add_lookup(32'h1234_5678, 3'd5, 0);
    add_lookup(32'h1234_5678, 3'd7, 0);
    add_lookup(32'hFFFF_FFFF, 3'd7, 2);

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p < 5) begin
        add_cfg(CFG_LINE_SIZE_LOG2, CFG_DATA_W'(cfg_plan[p][0]));
        add_cfg(CFG_SETS_LOG2, CFG_DATA_W'(cfg_plan[p][1]));
        add_cfg(CFG_WAYS_LOG2, CFG_DATA_W'(cfg_plan[p][2]));
      end else begin
        add_cfg(CFG_LINE_SIZE_LOG2, CFG_DATA_W'($urandom_range(0, 7)));
        add_cfg(CFG_SETS_LOG2, CFG_DATA_W'($urandom_range(0, 7)));
        add_cfg(CFG_WAYS_LOG2, CFG_DATA_W'($urandom_range(0, 7)));
      end
      if ($urandom_range(0, 3) == 0) add_cfg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom_range(0, 7)));
      add_random_phase(PHASE_ITEMS);
    end

    while (pending_reqs.size() != 0 || start || expected_lookups.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_lookups.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
